FILE: rtl/core/segregated_pool_allocator_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the segregated pool allocator
// Shared property templates, clocked on clk and disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef SEGREGATED_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define SEGREGATED_POOL_ALLOCATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segregated pool allocator: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segregated pool allocator: next-cycle check failed");

`endif

FILE: rtl/core/spa_pkg.sv
// ---------------------------------------------------------------------------
// spa_pkg
// Types, constants and helper functions shared by the pool allocator modules.
// ---------------------------------------------------------------------------
package spa_pkg;

  // Heap geometry.
  localparam int HEAP_CHUNKS   = 16;
  localparam int CHUNK_BYTES   = 4096;
  localparam int NUM_CLASSES   = 8;
  localparam int GRANULE_SHIFT = 5;
  localparam int CHUNK_SHIFT   = 12;
  localparam int GRANULES      = HEAP_CHUNKS * (CHUNK_BYTES >> GRANULE_SHIFT);

  // Derived widths.
  localparam int CHUNK_W = $clog2(HEAP_CHUNKS);
  localparam int BRK_W   = CHUNK_W + 1;
  localparam int OFF_W   = CHUNK_SHIFT - GRANULE_SHIFT;
  localparam int GIDX_W  = CHUNK_W + OFF_W;
  localparam int LINK_W  = GIDX_W + 1;
  localparam int CLASS_W = $clog2(NUM_CLASSES);
  localparam int ADDR_W  = 16;
  localparam int SIZE_W  = 16;
  localparam int LIMIT_W = 5;

  // Request limits.
  localparam logic [SIZE_W-1:0]  MAX_POOL_SIZE = 16'd4088;
  localparam logic [ADDR_W-1:0]  HDR_BYTES     = 16'd8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(HEAP_CHUNKS);

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_OOM       = 2'd2,
    ST_INVALID   = 2'd3
  } spa_status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_CARVE,
    S_POP
  } spa_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd_head;
    logic finish;
    logic carve_init;
    logic carve_step;
    logic pop;
  } spa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_alloc;
    logic too_large;
    logic head_valid;
    logic can_carve;
    logic carve_last;
  } spa_stat_t;

  // Size class from the request size plus header rounding (size + 7).
  // The class is the bit length of that value less five.
  function automatic logic [CLASS_W-1:0] class_of(input logic [11:0] v);
    logic [CLASS_W-1:0] c;
    c = '0;
    for (int b = 5; b < 12; b++) begin
      if (v[b]) begin
        c = CLASS_W'(b - 4);
      end
    end
    return c;
  endfunction

  // Low chunk-offset bits that must be zero for a block of class c.
  function automatic logic [11:0] align_mask(input logic [CLASS_W-1:0] c);
    logic [12:0] m;
    m = (13'd32 << c) - 13'd1;
    return m[11:0];
  endfunction

endpackage

FILE: rtl/core/spa_ram.sv
// ---------------------------------------------------------------------------
// spa_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Up to one write and one read per cycle at the shared address; a read during a write returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/spa_ctrl.sv
// ---------------------------------------------------------------------------
// spa_ctrl
// Request sequencer: decode, pop, free and chunk carving steps.
// ---------------------------------------------------------------------------
module spa_ctrl import spa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  spa_stat_t stat,
  output logic      busy,
  output spa_cmd_t  cmd
);

  spa_state_t state_r;
  spa_state_t state_nxt;
  logic       accept;

  // The block takes a word when idle or while finishing a pop.
  assign busy   = (state_r != S_IDLE) && (state_r != S_POP);
  assign accept = start && !busy;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (stat.is_alloc && !stat.too_large && stat.head_valid) begin
          state_nxt = S_POP;
        end else if (stat.is_alloc && !stat.too_large && stat.can_carve) begin
          state_nxt = S_CARVE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CARVE: begin
        if (stat.carve_last) state_nxt = S_DECODE;
      end
      S_POP: begin
        state_nxt = accept ? S_DECODE : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    cmd.load = accept;
    case (state_r)
      S_DECODE: begin
        if (stat.is_alloc && !stat.too_large && stat.head_valid) begin
          cmd.rd_head = 1'b1;
        end else if (stat.is_alloc && !stat.too_large && stat.can_carve) begin
          cmd.carve_init = 1'b1;
        end else begin
          cmd.finish = 1'b1;
        end
      end
      S_CARVE: cmd.carve_step = 1'b1;
      S_POP:   cmd.pop = 1'b1;
      default: ;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/spa_dp.sv
// ---------------------------------------------------------------------------
// spa_dp
// Allocator datapath: list heads, chunk records, link memory and results.
// ---------------------------------------------------------------------------
`include "segregated_pool_allocator_top_assert.svh"

module spa_dp import spa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  spa_cmd_t           cmd,
  output spa_stat_t          stat,
  input  logic               in_op,
  input  logic [SIZE_W-1:0]  in_req_size,
  input  logic [ADDR_W-1:0]  in_addr,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  output logic               out_valid,
  output logic [ADDR_W-1:0]  out_result_addr,
  output logic [1:0]         out_status,
  output logic [CLASS_W-1:0] out_size_class
);

  // Latched request word.
  logic              op_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] addr_r;

  // Allocator state.
  logic [LIMIT_W-1:0] limit_r;
  logic [BRK_W-1:0]   brk_r;
  logic [BRK_W-1:0]   brk_nxt;
  logic [NUM_CLASSES-1:0] head_vld_r;
  logic [GIDX_W-1:0]  head_idx_r [NUM_CLASSES];
  logic [HEAP_CHUNKS-1:0] rec_vld_r;
  logic [CLASS_W-1:0] rec_cls_r [HEAP_CHUNKS];
  logic [OFF_W-1:0]   off_r;
  logic [OFF_W-1:0]   off_nxt;

  // Result registers.
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [ADDR_W-1:0]  out_addr_nxt;
  spa_status_t        out_status_r;
  spa_status_t        out_status_nxt;
  logic [CLASS_W-1:0] out_cls_r;
  logic [CLASS_W-1:0] out_cls_nxt;
  logic [BRK_W-1:0]   out_chunk;

  // Decode signals.
  logic [SIZE_W-1:0]  size_eff;
  logic [11:0]        size_round;
  logic               too_large;
  logic [CLASS_W-1:0] cls;
  logic [LIMIT_W-1:0] eff_limit;
  logic [ADDR_W-1:0]  fbase;
  logic [CHUNK_W-1:0] fchunk;
  logic [CLASS_W-1:0] fcls;
  logic [GIDX_W-1:0]  fgran;
  logic               free_ok;
  logic               free_commit;

  // Carving signals.
  logic [CHUNK_W-1:0] carve_chunk;
  logic [OFF_W:0]     carve_sum;
  logic               carve_last;

  // Link memory port.
  logic              ram_we;
  logic [GIDX_W-1:0] ram_addr;
  logic [LINK_W-1:0] ram_wdata;
  logic [LINK_W-1:0] ram_rdata;

  // Allocate decode: size class, size check and chunk budget.
  assign size_eff   = (size_r == '0) ? SIZE_W'(1) : size_r;
  assign too_large  = size_eff > MAX_POOL_SIZE;
  assign size_round = size_eff[11:0] + 12'd7;
  assign cls        = class_of(size_round);
  assign eff_limit  = (limit_r > LIMIT_W'(HEAP_CHUNKS)) ? LIMIT_W'(HEAP_CHUNKS) : limit_r;

  // Free decode: owning chunk, its class and block alignment.
  assign fbase   = addr_r - HDR_BYTES;
  assign fchunk  = fbase[ADDR_W-1 -: CHUNK_W];
  assign fcls    = rec_cls_r[fchunk];
  assign fgran   = fbase[ADDR_W-1 -: GIDX_W];
  assign free_ok = (addr_r >= HDR_BYTES) && ({1'b0, fchunk} < brk_r) &&
                   rec_vld_r[fchunk] && ((fbase[11:0] & align_mask(fcls)) == 12'd0);
  assign free_commit = cmd.finish && (op_r == OP_FREE) && free_ok;

  // Carving walks the new chunk one block per cycle.
  assign carve_chunk = brk_r[CHUNK_W-1:0];
  assign carve_sum   = {1'b0, off_r} + ((OFF_W + 1)'(1) << cls);
  assign carve_last  = carve_sum[OFF_W];

  // Status to the controller.
  assign stat.is_alloc   = (op_r == OP_ALLOC);
  assign stat.too_large  = too_large;
  assign stat.head_valid = head_vld_r[cls];
  assign stat.can_carve  = brk_r < BRK_W'(eff_limit);
  assign stat.carve_last = carve_last;

  // Link memory port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = head_idx_r[cls];
    ram_wdata = {head_vld_r[fcls], head_idx_r[fcls]};
    if (free_commit) begin
      ram_we   = 1'b1;
      ram_addr = fgran;
    end else if (cmd.carve_step) begin
      ram_we    = 1'b1;
      ram_addr  = {carve_chunk, off_r};
      ram_wdata = carve_last ? '0 : {1'b1, carve_chunk, carve_sum[OFF_W-1:0]};
    end
  end

  spa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (GRANULES)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Next values for counters and result registers.
  always_comb begin
    off_nxt        = off_r;
    brk_nxt        = brk_r;
    out_valid_nxt  = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_cls_nxt    = out_cls_r;
    if (cmd.carve_init) off_nxt = '0;
    if (cmd.carve_step) begin
      off_nxt = carve_sum[OFF_W-1:0];
      if (carve_last) brk_nxt = brk_r + BRK_W'(1);
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      out_addr_nxt  = '0;
      if (op_r == OP_FREE) begin
        out_status_nxt = free_ok ? ST_OK : ST_INVALID;
        out_cls_nxt    = free_ok ? fcls : '0;
      end else begin
        out_status_nxt = too_large ? ST_TOO_LARGE : ST_OOM;
        out_cls_nxt    = too_large ? '0 : cls;
      end
    end
    if (cmd.pop) begin
      out_valid_nxt  = 1'b1;
      out_addr_nxt   = {head_idx_r[cls], GRANULE_SHIFT'(0)} + HDR_BYTES;
      out_status_nxt = ST_OK;
      out_cls_nxt    = cls;
    end
  end

  // Request word capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      size_r <= in_req_size;
      addr_r <= in_addr;
    end
  end

  // Control state: limit, break, valid bits and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      brk_r       <= '0;
      head_vld_r  <= '0;
      rec_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      brk_r       <= brk_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.carve_step && carve_last) begin
        rec_vld_r[carve_chunk] <= 1'b1;
        head_vld_r[cls]        <= 1'b1;
      end
      if (free_commit) head_vld_r[fcls] <= 1'b1;
      if (cmd.pop) head_vld_r[cls] <= ram_rdata[LINK_W-1];
    end
  end

  // Payload state: list head indexes, chunk classes, carve offset, results.
  always_ff @(posedge clk) begin
    off_r        <= off_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_cls_r    <= out_cls_nxt;
    if (cmd.carve_step && carve_last) begin
      rec_cls_r[carve_chunk] <= cls;
      head_idx_r[cls]        <= {carve_chunk, OFF_W'(0)};
    end
    if (free_commit) head_idx_r[fcls] <= fgran;
    if (cmd.pop) head_idx_r[cls] <= ram_rdata[GIDX_W-1:0];
  end

  assign out_valid       = out_valid_r;
  assign out_result_addr = out_addr_r;
  assign out_status      = out_status_r;
  assign out_size_class  = out_cls_r;

  // Chunk that holds the block on the result port.
  assign out_chunk = {1'b0, out_addr_r[ADDR_W-1 -: CHUNK_W]};

  // The number of claimed chunks never passes the heap size.
  `SPA_ASSERT_SAME(a_brk_bound, 1'b1, brk_r <= BRK_W'(HEAP_CHUNKS))
  // Every result strobe comes from a finish or a pop in the cycle before.
  `SPA_ASSERT_SAME(a_strobe_src, out_valid_r, $past(cmd.finish) || $past(cmd.pop))
  // A returned block always lies in a chunk that has been claimed.
  `SPA_ASSERT_SAME(a_addr_claimed, out_valid_r && out_addr_r != '0, out_chunk < brk_r)
  // Finishing a carve leaves the class list non-empty for the retry.
  `SPA_ASSERT_NEXT(a_carve_head, cmd.carve_step && carve_last, stat.head_valid)
  // A head read is always followed by the pop that uses its link.
  `SPA_ASSERT_NEXT(a_pop_after_read, cmd.rd_head, cmd.pop)

endmodule

FILE: rtl/core/segregated_pool_allocator_top.sv
// Free and rejected requests strobe a result registered from the decode state after start is taken;
// an allocate from a non-empty list reads the list head in decode and strobes from the pop state.
// An allocate that claims a new chunk first carves it, one link-RAM write a block, then decodes again.
// A new word is taken only while idle or while a pop finishes, never during decode or carving.
// Reset (rst_n low, synchronous): all lists empty, no chunks claimed, chunk_limit 16;
// the link RAM is not cleared. Results are strobed and the receiver cannot stall.
// ---------------------------------------------------------------------------
// segregated_pool_allocator_top
// Size-class pool allocator over a heap of 4096-byte chunks.
// ---------------------------------------------------------------------------
module segregated_pool_allocator_top import spa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [SIZE_W-1:0]  in_req_size,
  input  logic [ADDR_W-1:0]  in_addr,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  output logic               out_valid,
  output logic [ADDR_W-1:0]  out_result_addr,
  output logic [1:0]         out_status,
  output logic [CLASS_W-1:0] out_size_class
);

  spa_cmd_t  cmd;
  spa_stat_t stat;

  // Sequencer.
  spa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath with the link memory.
  spa_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (in_op),
    .in_req_size     (in_req_size),
    .in_addr         (in_addr),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_result_addr (out_result_addr),
    .out_status      (out_status),
    .out_size_class  (out_size_class)
  );

endmodule
